// ===== src/trd_pkg.sv =====
// Shared types and constants for the record deframer.
package trd_pkg;

  localparam logic [7:0] APP_DATA_TYPE = 8'd23;
  localparam logic [7:0] VERSION_BYTE  = 8'h03;
  localparam logic [2:0] HDR_STORED    = 3'd4;

  // Status codes carried on the record channel.
  localparam logic ST_PAYLOAD = 1'b0;
  localparam logic ST_FAULT   = 1'b1;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       record_last;
    logic       status;
  } result_t;

endpackage

// ===== src/trd_parser.sv =====
// Header collection, header check and payload count for the record deframer.
module trd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        data,
  output logic              res_valid,
  output trd_pkg::result_t  res
);

  logic        in_payload;
  logic        in_payload_next;
  logic [2:0]  header_position;
  logic [2:0]  header_position_next;
  logic [15:0] bytes_remaining;
  logic [15:0] bytes_remaining_next;
  logic [7:0]  header_bytes [4];
  logic [15:0] len;
  logic        hdr_ok;
  logic        last;

  assign len    = {header_bytes[3], data};
  assign hdr_ok = (header_bytes[0] == trd_pkg::APP_DATA_TYPE) &&
                  (header_bytes[1] == trd_pkg::VERSION_BYTE) &&
                  (header_bytes[2] == trd_pkg::VERSION_BYTE) &&
                  (len != 16'd0);
  assign last   = (bytes_remaining <= 16'd1);

  always_comb begin
    in_payload_next      = in_payload;
    header_position_next = header_position;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res.payload_byte     = data;
    res.record_last      = last;
    res.status           = trd_pkg::ST_PAYLOAD;
    if (in_payload) begin
      res_valid = 1'b1;
      if (last) begin
        bytes_remaining_next = 16'd0;
        in_payload_next      = 1'b0;
      end else begin
        bytes_remaining_next = bytes_remaining - 16'd1;
      end
    end else if (header_position < trd_pkg::HDR_STORED) begin
      header_position_next = header_position + 3'd1;
    end else begin
      header_position_next = 3'd0;
      if (hdr_ok) begin
        bytes_remaining_next = len;
        in_payload_next      = 1'b1;
      end else begin
        // fault result
        res_valid        = 1'b1;
        res.payload_byte = 8'd0;
        res.record_last  = 1'b0;
        res.status       = trd_pkg::ST_FAULT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_payload      <= 1'b0;
      header_position <= 3'd0;
      bytes_remaining <= 16'd0;
    end else if (step) begin
      in_payload      <= in_payload_next;
      header_position <= header_position_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

  // store the first four header bytes
  always_ff @(posedge clk) begin
    if (step && !in_payload && header_position < trd_pkg::HDR_STORED) begin
      header_bytes[header_position[1:0]] <= data;
    end
  end

  a_pay_nonzero: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> bytes_remaining != 16'd0)
    else $error("payload state with no bytes left");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    header_position <= trd_pkg::HDR_STORED)
    else $error("header position out of range");

  a_pay_no_hdr: assert property (@(posedge clk) disable iff (rst)
    in_payload |-> header_position == 3'd0)
    else $error("header count held during payload");

  a_enter_pay: assert property (@(posedge clk) disable iff (rst)
    (step && !in_payload && header_position == trd_pkg::HDR_STORED && hdr_ok) |=>
      (in_payload && bytes_remaining == $past(len)))
    else $error("accepted header did not load the length");

endmodule

// ===== src/tls_record_deframer.sv =====
// Top level of the record deframer: input register, parser, result register.
//
// Usage:
//   Wire channel: wire_valid / wire_stall / wire_byte carry the framed byte
//   stream, one word per accepted handshake. Record channel: rec_valid /
//   rec_stall carry payload_byte, record_last and status, one word per result.
//   Each record is a 5-word header (type 23, version 3.3, nonzero length)
//   followed by that many payload words; the last payload word has
//   record_last set. A bad header yields one word with status 1 and zero
//   payload, and the next wire word starts a new header.
//   Header words produce no output word, but for a bad header's fault word.
//   An accepted payload word passes the input register, then the result
//   register, before it is presented on the record channel.
//   Throughput: one wire word per cycle unless rec_stall holds a full result
//   register; set by the single parser pass between the two registers.
//   Reset: rst (synchronous) empties both registers and returns the parser
//   to header collection with no bytes pending.
//   Stall: while rec_stall holds a full result register, the input register
//   holds its word and wire_stall rises once it is full as well.
module tls_record_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       wire_valid,
  output logic       wire_stall,
  input  logic [7:0] wire_byte,
  output logic       rec_valid,
  input  logic       rec_stall,
  output logic [7:0] payload_byte,
  output logic       record_last,
  output logic       status
);

  // input register
  logic              in_full;
  logic [7:0]        in_byte;
  // result register
  logic              out_full;
  trd_pkg::result_t  out_res;
  // parser outputs
  logic              res_valid;
  trd_pkg::result_t  res;
  logic              advance;
  logic              accept;

  // advance the input word through the parser when the result slot frees up
  assign advance    = in_full && (!out_full || !rec_stall);
  assign wire_stall = in_full && !advance;
  assign accept     = wire_valid && !wire_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= wire_byte;
    end
  end

  trd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data      (in_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // load a result on advance; drop the held one once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (advance) begin
      out_full <= res_valid;
    end else if (!rec_stall) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign rec_valid    = out_full;
  assign payload_byte = out_res.payload_byte;
  assign record_last  = out_res.record_last;
  assign status       = out_res.status;

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    wire_stall |-> (in_full && out_full && rec_stall))
    else $error("wire stalled without a blocked pipeline");

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (rec_valid && status) |-> (payload_byte == 8'd0 && !record_last))
    else $error("fault word carries payload");

  a_hold_input: assert property (@(posedge clk) disable iff (rst)
    (in_full && !advance) |=> (in_full && $stable(in_byte)))
    else $error("input word lost while blocked");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the TLS record deframer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam time CLK_PERIOD   = 20ns;
  localparam int  RESET_CYCLES = 10;
  localparam int  IDLE_PCT     = 13;
  localparam int  RANDOM_WORDS = 1050;
  localparam int  DRAIN_CYCLES = 10;
  // No accepted word in either direction for this long means the block hung.
  localparam int  HANG_LIMIT   = 2000;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       wire_valid = 1'b0;
  logic       wire_stall;
  logic [7:0] wire_byte = 8'h00;
  logic       rec_valid;
  logic       rec_stall = 1'b0;
  logic [7:0] payload_byte;
  logic       record_last;
  logic       status;

  // Predicted deframer state, advanced once per accepted wire word.
  logic        rx_in_record = 1'b0;
  logic [2:0]  rx_hdr_count = '0;
  logic [7:0]  rx_hdr [4];
  logic [15:0] rx_left = '0;

  // Record-channel words still owed by the block, oldest first.
  trd_pkg::result_t deframed_q[$];

  int  n_errors   = 0;
  int  words_in   = 0;
  int  idle_count = 0;
  // While set, neither side inserts gaps or stalls.
  bit  calm       = 1'b0;

  tls_record_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .wire_valid   (wire_valid),
    .wire_stall   (wire_stall),
    .wire_byte    (wire_byte),
    .rec_valid    (rec_valid),
    .rec_stall    (rec_stall),
    .payload_byte (payload_byte),
    .record_last  (record_last),
    .status       (status)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Advance the predicted parser by one wire byte. Return 1 when the byte
  // produces a record-channel word, and hand that word back in r.
  function automatic bit deframe_byte(input logic [7:0] b, output trd_pkg::result_t r);
    logic [15:0] rec_len;
    r = '0;
    // Inside a record: pass the byte through, flag the final one.
    if (rx_in_record) begin
      r.payload_byte = b;
      r.record_last  = (rx_left <= 16'd1);
      r.status       = trd_pkg::ST_PAYLOAD;
      if (r.record_last) begin
        rx_left      = '0;
        rx_in_record = 1'b0;
      end else begin
        rx_left = rx_left - 16'd1;
      end
      return 1'b1;
    end
    // First four header bytes are held silently.
    if (rx_hdr_count < trd_pkg::HDR_STORED) begin
      rx_hdr[rx_hdr_count[1:0]] = b;
      rx_hdr_count = rx_hdr_count + 3'd1;
      return 1'b0;
    end
    // Fifth byte is the low length byte, used directly to judge the header.
    rec_len      = {rx_hdr[3], b};
    rx_hdr_count = '0;
    if (rx_hdr[0] == trd_pkg::APP_DATA_TYPE && rx_hdr[1] == trd_pkg::VERSION_BYTE &&
        rx_hdr[2] == trd_pkg::VERSION_BYTE && rec_len != 16'd0) begin
      rx_left      = rec_len;
      rx_in_record = 1'b1;
      return 1'b0;
    end
    // Rejected header: one fault word, then start over at the next byte.
    r.status = trd_pkg::ST_FAULT;
    return 1'b1;
  endfunction

  // Present one wire word, hold it through any stall, and predict its effect
  // once it is taken. Valid stays high on exit so back-to-back words flow.
  task automatic send_byte(input logic [7:0] b);
    trd_pkg::result_t r;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      wire_valid <= 1'b0;
      @(posedge clk);
    end
    wire_valid <= 1'b1;
    wire_byte  <= b;
    do @(posedge clk); while (wire_stall);
    words_in++;
    if (deframe_byte(b, r))
      deframed_q.push_back(r);
  endtask

  task automatic send_header(input logic [7:0] ctype, input logic [7:0] major,
                             input logic [7:0] minor, input logic [15:0] len);
    send_byte(ctype);
    send_byte(major);
    send_byte(minor);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom_range(255)));
  endtask

  // Feed filler until the predicted parser is back at a header boundary.
  task automatic realign();
    while (rx_in_record || rx_hdr_count != 3'd0)
      send_byte(8'($urandom_range(255)));
  endtask

  // Shortest records, with the payload byte extremes; a one-byte record is
  // both first and last.
  task automatic test_short_records();
    send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE, trd_pkg::VERSION_BYTE, 16'd1);
    send_byte(8'hFF);
    send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE, trd_pkg::VERSION_BYTE, 16'd2);
    send_byte(8'h00);
    send_byte(8'hA5);
  endtask

  // Each way a header can be rejected, one fault word apiece.
  task automatic test_header_faults();
    send_header(8'd22, trd_pkg::VERSION_BYTE, trd_pkg::VERSION_BYTE, 16'd4);
    send_header(trd_pkg::APP_DATA_TYPE, 8'h02, trd_pkg::VERSION_BYTE, 16'd4);
    send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE, 8'h01, 16'd4);
    send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE, trd_pkg::VERSION_BYTE, 16'd0);
    send_header(8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
  endtask

  // Length carried only in the high byte: a zero low byte must not count
  // as a zero length.
  task automatic test_length_high_byte();
    send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE, trd_pkg::VERSION_BYTE,
                16'h0100);
    send_payload(256);
  endtask

  // Mostly well-formed records of random size and content, mixed with bad
  // headers, torn header fragments and random headers.
  task automatic test_random_stream();
    int          start;
    int          pick;
    int          n;
    logic [7:0]  v;
    logic [15:0] len;
    start = words_in;
    while (words_in - start < RANDOM_WORDS) begin
      // Hold a stretch of the stream with no gaps or stalls at all.
      calm = (words_in - start >= 400 && words_in - start < 700);
      pick = $urandom_range(99);
      if (pick < 70) begin
        len = ($urandom_range(99) < 92) ? 16'($urandom_range(12, 1))
                                        : 16'($urandom_range(300, 13));
        send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE, trd_pkg::VERSION_BYTE,
                    len);
        send_payload(int'(len));
      end else if (pick < 82) begin
        len = 16'($urandom_range(16'hFFFF));
        case ($urandom_range(3))
          0: begin
            do v = 8'($urandom_range(255)); while (v == trd_pkg::APP_DATA_TYPE);
            send_header(v, trd_pkg::VERSION_BYTE, trd_pkg::VERSION_BYTE, len);
          end
          1: begin
            do v = 8'($urandom_range(255)); while (v == trd_pkg::VERSION_BYTE);
            send_header(trd_pkg::APP_DATA_TYPE, v, trd_pkg::VERSION_BYTE, len);
          end
          2: begin
            do v = 8'($urandom_range(255)); while (v == trd_pkg::VERSION_BYTE);
            send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE, v, len);
          end
          default: send_header(trd_pkg::APP_DATA_TYPE, trd_pkg::VERSION_BYTE,
                               trd_pkg::VERSION_BYTE, 16'd0);
        endcase
      end else if (pick < 90) begin
        // Torn header: random filler completes the partial header and realigns.
        n = $urandom_range(4, 1);
        send_byte($urandom_range(1) ? trd_pkg::APP_DATA_TYPE : 8'($urandom_range(255)));
        repeat (n - 1) send_byte(8'($urandom_range(255)));
        realign();
      end else begin
        send_payload(5);
        realign();
      end
    end
    calm = 1'b0;
  endtask

  // Receiver side: stall at random except during the calm stretch.
  always @(posedge clk)
    rec_stall <= !calm && ($urandom_range(99) < IDLE_PCT);

  // Compare every accepted record-channel word with the oldest prediction.
  always @(posedge clk) begin
    trd_pkg::result_t want;
    if (!rst && rec_valid && !rec_stall) begin
      if (deframed_q.size() == 0) begin
        $display({"%0t: unexpected word: expected none, actual payload_byte %02h",
                  " record_last %0b status %0b"},
                 $time, payload_byte, record_last, status);
        n_errors++;
      end else begin
        want = deframed_q.pop_front();
        if (payload_byte !== want.payload_byte) begin
          $display("%0t: payload_byte expected %02h actual %02h",
                   $time, want.payload_byte, payload_byte);
          n_errors++;
        end
        if (record_last !== want.record_last) begin
          $display("%0t: record_last expected %0b actual %0b",
                   $time, want.record_last, record_last);
          n_errors++;
        end
        if (status !== want.status) begin
          $display("%0t: status expected %0b actual %0b", $time, want.status, status);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (rst || (wire_valid && !wire_stall) || (rec_valid && !rec_stall))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= HANG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, HANG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_short_records();
    test_header_faults();
    test_length_high_byte();
    test_random_stream();

    // Drop valid, drain every owed word, then watch for stray extras.
    wire_valid <= 1'b0;
    while (deframed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
